### sv/button_multi_press_counter_assert.svh
// Assertion macros used by the checker file of the multi-press counter.
`ifndef BUTTON_MULTI_PRESS_COUNTER_ASSERT_SVH
`define BUTTON_MULTI_PRESS_COUNTER_ASSERT_SVH

// Checked at every rising edge, idle while reset is asserted.
`define BMPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define BMPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/bmpc_pkg.sv
// ----------------------------------------------------------------------------
// Multi-press counter package
// Shared types and constants for the debounced multi-press counter.
// ----------------------------------------------------------------------------
package bmpc_pkg;

  localparam int TIME_W    = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CLICK_W   = 2;

  localparam logic [CFG_W-1:0]   DEBOUNCE_RST = 16'd50;
  localparam logic [CFG_W-1:0]   WINDOW_RST   = 16'd400;
  localparam logic [CLICK_W-1:0] CLICK_MAX    = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_WINDOW   = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] window_ms;
  } cfg_t;

endpackage

### sv/bmpc_cfg_regs.sv
// ----------------------------------------------------------------------------
// Multi-press counter configuration registers
// Holds the debounce interval and the quiet window, written by index.
// ----------------------------------------------------------------------------
module bmpc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bmpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bmpc_pkg::CFG_W-1:0]     cfg_wdata,
  output bmpc_pkg::cfg_t                 cfg
);
  import bmpc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_DEBOUNCE: cfg_nxt.debounce_ms = cfg_wdata;
        REG_WINDOW:   cfg_nxt.window_ms   = cfg_wdata;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms <= DEBOUNCE_RST;
      cfg_r.window_ms   <= WINDOW_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### sv/bmpc_sampler.sv
// ----------------------------------------------------------------------------
// Multi-press counter sampler
// Debounces the switch, counts presses and reports a finished burst.
// ----------------------------------------------------------------------------
module bmpc_sampler (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic [bmpc_pkg::TIME_W-1:0]  now_ms,
  input  logic                         switch_level,
  input  bmpc_pkg::cfg_t               cfg,
  output logic [bmpc_pkg::CLICK_W-1:0] click_count
);
  import bmpc_pkg::*;

  logic [TIME_W-1:0]  last_sample_r, last_sample_nxt;
  logic [TIME_W-1:0]  last_press_r,  last_press_nxt;
  logic               held_r,        held_nxt;
  logic [CLICK_W-1:0] pending_r,     pending_nxt;

  logic [TIME_W-1:0]  sample_gap;
  logic [TIME_W-1:0]  press_gap;
  logic               sample_ok;
  logic               press;
  logic [CLICK_W-1:0] pending_upd;
  logic               report;

  always_comb begin
    sample_gap      = now_ms - last_sample_r;
    sample_ok       = sample_gap >= {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_ms};
    press           = sample_ok && !switch_level && !held_r;
    held_nxt        = sample_ok ? !switch_level : held_r;
    last_sample_nxt = sample_ok ? now_ms : last_sample_r;

    pending_upd = pending_r;
    if (press && (pending_r != CLICK_MAX)) begin
      pending_upd = pending_r + CLICK_W'(1);
    end
    last_press_nxt = press ? now_ms : last_press_r;

    press_gap   = now_ms - last_press_nxt;
    report      = (pending_upd != '0) &&
                  (press_gap > {{(TIME_W-CFG_W){1'b0}}, cfg.window_ms});
    click_count = report ? pending_upd : '0;
    pending_nxt = report ? '0 : pending_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_sample_r <= '0;
      last_press_r  <= '0;
      held_r        <= 1'b0;
      pending_r     <= '0;
    end else if (step) begin
      last_sample_r <= last_sample_nxt;
      last_press_r  <= last_press_nxt;
      held_r        <= held_nxt;
      pending_r     <= pending_nxt;
    end
  end

endmodule

### sv/button_multi_press_counter.sv
// ----------------------------------------------------------------------------
// Debounced multi-press counter
// Each input word is a poll carrying a millisecond timestamp and the raw,
// active-low switch level. Each poll gives exactly one output word: zero, or
// the number of presses (clamped to three) in a burst that has just gone
// quiet for longer than the window.
// Channels use valid and stall; a word moves when valid is high and stall is
// low. The configuration port writes the debounce interval (index 0) and the
// window (index 1); the user is to write it only while the block is idle, and
// the block itself does not enforce this. An input word is held in the input
// register, then passes through the sampler logic into the output register,
// which presents the output word. One poll is taken every cycle while the
// output is not stalled; the state update of the sampler sets that rate.
// A synchronous reset restores the default configuration, clears the burst
// state and empties both registers. When the receiver stalls, the output word
// holds and the input register may still take one more word before in_stall
// rises.
// ----------------------------------------------------------------------------
module button_multi_press_counter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [bmpc_pkg::TIME_W-1:0]    in_now_ms,
  input  logic                           in_switch_level,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bmpc_pkg::CLICK_W-1:0]   out_click_count,
  input  logic                           cfg_we,
  input  logic [bmpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bmpc_pkg::CFG_W-1:0]     cfg_wdata
);
  import bmpc_pkg::*;

  cfg_t               cfg;
  logic               s1_valid_r;
  logic [TIME_W-1:0]  s1_now_r;
  logic               s1_level_r;
  logic               out_valid_r;
  logic [CLICK_W-1:0] out_click_r;
  logic [CLICK_W-1:0] click_nxt;
  logic               out_free;
  logic               s1_move;
  logic               in_take;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  bmpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bmpc_sampler u_sampler (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (s1_move),
    .now_ms       (s1_now_r),
    .switch_level (s1_level_r),
    .cfg          (cfg),
    .click_count  (click_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_now_r   <= in_now_ms;
      s1_level_r <= in_switch_level;
    end
    if (s1_move) begin
      out_click_r <= click_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_click_count = out_click_r;

endmodule

### sv/bmpc_checker.sv
// ----------------------------------------------------------------------------
// Multi-press counter checker
// Port-level assertions on the output channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "button_multi_press_counter_assert.svh"

module bmpc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [bmpc_pkg::CLICK_W-1:0]   out_click_count
);
  import bmpc_pkg::*;

  logic last_report_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_report_r <= 1'b0;
    end else if (out_valid && !out_stall) begin
      last_report_r <= (out_click_count != '0);
    end
  end

  `BMPC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "output valid after reset")
  `BMPC_ASSERT(a_hold_valid, out_valid && out_stall |=> out_valid, "stalled word dropped")
  `BMPC_ASSERT(a_hold_data, out_valid && out_stall |=> $stable(out_click_count), "stalled word changed")
  `BMPC_ASSERT(a_no_stall_empty, !out_valid |-> !in_stall, "input stalled with output empty")
  `BMPC_ASSERT(a_no_double_report, out_valid && last_report_r |-> out_click_count == '0, "two bursts reported on consecutive polls")

endmodule

bind button_multi_press_counter bmpc_checker u_bmpc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_click_count (out_click_count)
);
